### sv/sss_pkg.sv
`default_nettype none

package sss_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int WSW = XW + 1;
	localparam int HSW = YW + 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam int COORD_W = 10;
	localparam int SUM_W   = 30;
	localparam int COUNT_W = 21;

	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = CFG_DATA_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} sss_reg_t;

	// Access to the line store: one read and one write per cycle.
	typedef struct packed {
		logic          rd_en;
		logic [XW-1:0] rd_addr;
		logic          wr_en;
		logic [XW-1:0] wr_addr;
		logic [1:0]    wr_data;
	} sss_ls_req_t;

endpackage

`default_nettype wire

### sv/sss_pix_if.sv
`default_nettype none

interface sss_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask_byte;

	modport source (output valid, output mask_byte, input ready);
	modport sink (input valid, input mask_byte, output ready);
endinterface

`default_nettype wire

### sv/sss_cfg_if.sv
`default_nettype none

interface sss_cfg_if
	import sss_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/sss_res_if.sv
`default_nettype none

interface sss_res_if
	import sss_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               frame_empty;
	logic [COORD_W-1:0] box_min_x;
	logic [COORD_W-1:0] box_max_x;
	logic [COORD_W-1:0] box_min_y;
	logic [COORD_W-1:0] box_max_y;
	logic [SUM_W-1:0]   column_sum;
	logic [SUM_W-1:0]   row_sum;
	logic [COUNT_W-1:0] area_count;
	logic [COUNT_W-1:0] edge_count;

	modport source (
		output valid, output frame_empty, output box_min_x, output box_max_x,
		output box_min_y, output box_max_y, output column_sum, output row_sum,
		output area_count, output edge_count, input ready
	);
	modport sink (
		input valid, input frame_empty, input box_min_x, input box_max_x,
		input box_min_y, input box_max_y, input column_sum, input row_sum,
		input area_count, input edge_count, output ready
	);
endinterface

`default_nettype wire

### sv/sss_line_store.sv
`default_nettype none

module sss_line_store
	import sss_pkg::*;
(
	input  wire logic        clk,
	input  wire sss_ls_req_t req,
	output logic [1:0]       rd_data
);

	// Bit 0 holds the row one back, bit 1 the row two back.
	logic [1:0] mem [MAX_WIDTH];
	logic [1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

### sv/silhouette_shape_statistics.sv
`default_nettype none

// Channel | Role | Payload                                      | Request when
// pix     | sink | mask_byte                                    | valid && ready
// cfg     | sink | index, data (image_width, image_height)      | valid && ready
// res     | src  | frame_empty, box, column/row sums, counts    | valid && ready
//
// One pixel is taken every cycle; the line store has one read and one write port.
// The result is loaded into the output register from the s1 stage registers of the last pixel.
// The line store is not cleared at reset; entries read before they are written never
// reach a result.
// Input stalls only on a last pixel while the previous result is still untaken.

module silhouette_shape_statistics
	import sss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sss_pix_if.sink   pix,
	sss_cfg_if.sink   cfg,
	sss_res_if.source res
);

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [WSW-1:0]        w_eff;
	logic [HSW-1:0]        h_eff;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          last_col;
	logic          last_row;
	logic          pix_acc;

	logic          v_s1;
	logic          cur_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic          lastc_s1;
	logic          lastr_s1;

	sss_ls_req_t ls_req;
	logic [1:0]  ls_rd;

	logic prev_above_q;
	logic prev_two_above_q;
	logic prev_cur_q;
	logic prev_prev_above_q;

	logic [XW-1:0]      minx_q;
	logic [XW-1:0]      maxx_q;
	logic [YW-1:0]      miny_q;
	logic [YW-1:0]      maxy_q;
	logic [SUM_W-1:0]   xsum_q;
	logic [SUM_W-1:0]   ysum_q;
	logic [COUNT_W-1:0] area_q;
	logic [COUNT_W-1:0] edge_q;

	logic [XW-1:0]      minx_d;
	logic [XW-1:0]      maxx_d;
	logic [YW-1:0]      miny_d;
	logic [YW-1:0]      maxy_d;
	logic [SUM_W-1:0]   xsum_d;
	logic [SUM_W-1:0]   ysum_d;
	logic [COUNT_W-1:0] area_d;
	logic [COUNT_W-1:0] edge_d;

	logic       above;
	logic       two_above;
	logic       on_border;
	logic       inner_edge;
	logic       first_fg;
	logic [1:0] edge_inc;
	logic       frame_end_s1;

	logic res_valid_q;

	// Configuration.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data;
				REG_IMAGE_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(width_q) < 2) begin
			w_eff = WSW'(2);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WSW'(MAX_WIDTH);
		end else begin
			w_eff = WSW'(width_q);
		end
		if (int'(height_q) < 2) begin
			h_eff = HSW'(2);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = HSW'(MAX_HEIGHT);
		end else begin
			h_eff = HSW'(height_q);
		end
	end

	// Position and line store read.
	assign last_col  = {1'b0, col_q} >= (w_eff - WSW'(1));
	assign last_row  = {1'b0, row_q} >= (h_eff - HSW'(1));
	assign pix.ready = !(last_col && last_row && res_valid_q && !res.ready);
	assign pix_acc   = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + YW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cur_s1   <= pix.mask_byte != 8'd0;
			x_s1     <= col_q;
			y_s1     <= row_q;
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
		end
	end

	always_comb begin
		ls_req.rd_en   = pix_acc;
		ls_req.rd_addr = col_q;
		ls_req.wr_en   = v_s1;
		ls_req.wr_addr = x_s1;
		ls_req.wr_data = {ls_rd[0], cur_s1};
	end

	sss_line_store u_line_store (
		.clk     (clk),
		.req     (ls_req),
		.rd_data (ls_rd)
	);

	// Statistics update.
	always_comb begin
		above        = ls_rd[0];
		two_above    = ls_rd[1];
		frame_end_s1 = lastc_s1 && lastr_s1;
		first_fg     = area_q == '0;
		on_border    = (x_s1 == '0) || lastc_s1 || (y_s1 == '0) || lastr_s1;
		inner_edge   = (x_s1 > XW'(1)) && (y_s1 > YW'(1)) && prev_above_q &&
			(!prev_prev_above_q || !above || !prev_two_above_q || !prev_cur_q);
		edge_inc     = {1'b0, cur_s1 && on_border} + {1'b0, inner_edge};

		minx_d = minx_q;
		maxx_d = maxx_q;
		miny_d = miny_q;
		maxy_d = maxy_q;
		xsum_d = xsum_q;
		ysum_d = ysum_q;
		area_d = area_q;
		if (cur_s1) begin
			if (first_fg || x_s1 < minx_q) minx_d = x_s1;
			if (first_fg || x_s1 > maxx_q) maxx_d = x_s1;
			if (first_fg || y_s1 < miny_q) miny_d = y_s1;
			if (first_fg || y_s1 > maxy_q) maxy_d = y_s1;
			xsum_d = xsum_q + SUM_W'(x_s1);
			ysum_d = ysum_q + SUM_W'(y_s1);
			area_d = area_q + COUNT_W'(1);
		end
		edge_d = edge_q + COUNT_W'(edge_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minx_q            <= '0;
			maxx_q            <= '0;
			miny_q            <= '0;
			maxy_q            <= '0;
			xsum_q            <= '0;
			ysum_q            <= '0;
			area_q            <= '0;
			edge_q            <= '0;
			prev_above_q      <= 1'b0;
			prev_two_above_q  <= 1'b0;
			prev_cur_q        <= 1'b0;
			prev_prev_above_q <= 1'b0;
		end else if (v_s1) begin
			if (frame_end_s1) begin
				minx_q            <= '0;
				maxx_q            <= '0;
				miny_q            <= '0;
				maxy_q            <= '0;
				xsum_q            <= '0;
				ysum_q            <= '0;
				area_q            <= '0;
				edge_q            <= '0;
				prev_above_q      <= 1'b0;
				prev_two_above_q  <= 1'b0;
				prev_cur_q        <= 1'b0;
				prev_prev_above_q <= 1'b0;
			end else begin
				minx_q            <= minx_d;
				maxx_q            <= maxx_d;
				miny_q            <= miny_d;
				maxy_q            <= maxy_d;
				xsum_q            <= xsum_d;
				ysum_q            <= ysum_d;
				area_q            <= area_d;
				edge_q            <= edge_d;
				prev_prev_above_q <= prev_above_q;
				prev_above_q      <= above;
				prev_two_above_q  <= two_above;
				prev_cur_q        <= cur_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (v_s1 && frame_end_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && frame_end_s1) begin
			if (area_d == '0) begin
				res.frame_empty <= 1'b1;
				res.box_min_x   <= '0;
				res.box_max_x   <= '0;
				res.box_min_y   <= '0;
				res.box_max_y   <= '0;
				res.column_sum  <= '0;
				res.row_sum     <= '0;
				res.area_count  <= '0;
				res.edge_count  <= '0;
			end else begin
				res.frame_empty <= 1'b0;
				res.box_min_x   <= COORD_W'(minx_d);
				res.box_max_x   <= COORD_W'(maxx_d);
				res.box_min_y   <= COORD_W'(miny_d);
				res.box_max_y   <= COORD_W'(maxy_d);
				res.column_sum  <= xsum_d;
				res.row_sum     <= ysum_d;
				res.area_count  <= area_d;
				res.edge_count  <= edge_d;
			end
		end
	end

	assign res.valid = res_valid_q;

	// The output register is free whenever a frame completes.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && frame_end_s1) |-> !res_valid_q)
		else $error("result register overwritten before it was taken");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.frame_empty == (res.area_count == '0)))
		else $error("empty flag disagrees with area count");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.frame_empty) |->
		(res.box_min_x <= res.box_max_x && res.box_min_y <= res.box_max_y))
		else $error("bounding box corners out of order");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
	import sss_pkg::*;
;

	typedef struct packed {
		logic               frame_empty;
		logic [COORD_W-1:0] min_x;
		logic [COORD_W-1:0] max_x;
		logic [COORD_W-1:0] min_y;
		logic [COORD_W-1:0] max_y;
		logic [SUM_W-1:0]   col_sum;
		logic [SUM_W-1:0]   row_sum;
		logic [COUNT_W-1:0] area;
		logic [COUNT_W-1:0] perimeter;
	} shape_stats_t;

	typedef enum int {
		SHAPE_EMPTY,
		SHAPE_FULL,
		SHAPE_NOISE,
		SHAPE_BLOCK
	} shape_kind_t;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;

	sss_pix_if pix ();
	sss_cfg_if cfg ();
	sss_res_if res ();

	silhouette_shape_statistics dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.res    (res)
	);

	always #4 clk = ~clk;

	// Shadow of the size registers and of the block's per-frame state.
	logic [CFG_DATA_W-1:0] width_reg  = SIZE_RESET;
	logic [CFG_DATA_W-1:0] height_reg = SIZE_RESET;

	bit line_prev  [MAX_WIDTH];
	bit line_prev2 [MAX_WIDTH];
	bit [XW-1:0]      col;
	bit [YW-1:0]      row;
	bit [WSW-1:0]     lo_x;
	bit [WSW-1:0]     hi_x;
	bit [HSW-1:0]     lo_y;
	bit [HSW-1:0]     hi_y;
	bit [SUM_W:0]     sum_x;
	bit [SUM_W:0]     sum_y;
	bit [COUNT_W-1:0] fg_count;
	bit [COUNT_W-1:0] perim_count;
	bit up_d1;
	bit up_d2;
	bit up2_d1;
	bit cur_d1;

	shape_stats_t expected_stats [$];

	int errors = 0;
	int pixels_sent = 0;
	int frames_checked = 0;
	int cycle_count = 0;
	int pix_calm = 0;
	int res_calm = 0;

	function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] v,
			input int unsigned top);
		if (v < 2)
			return 2;
		if (v > top)
			return top;
		return 32'(v);
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic bit step_pixel(input logic [7:0] value, output shape_stats_t r);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		bit last_col;
		bit last_row;
		bit cur;
		bit up;
		bit up2;
		r = '0;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		x = 32'(col);
		y = 32'(row);
		last_col = x >= w - 1;
		last_row = y >= h - 1;
		cur = value != 8'h00;
		up = line_prev[col];
		up2 = line_prev2[col];

		if (cur) begin
			if (fg_count == 0 || x < lo_x)
				lo_x = WSW'(x);
			if (fg_count == 0 || x > hi_x)
				hi_x = WSW'(x);
			if (fg_count == 0 || y < lo_y)
				lo_y = HSW'(y);
			if (fg_count == 0 || y > hi_y)
				hi_y = HSW'(y);
			sum_x = sum_x + (SUM_W+1)'(x);
			sum_y = sum_y + (SUM_W+1)'(y);
			fg_count = fg_count + COUNT_W'(1);
			if (x == 0 || last_col || y == 0 || last_row)
				perim_count = perim_count + COUNT_W'(1);
		end

		// The pixel one row up and one column left now has all four neighbours known.
		if (x >= 2 && y >= 2 && up_d1 && (!up_d2 || !up || !up2_d1 || !cur_d1))
			perim_count = perim_count + COUNT_W'(1);

		up_d2 = up_d1;
		up_d1 = up;
		up2_d1 = up2;
		cur_d1 = cur;
		line_prev2[col] = up;
		line_prev[col] = cur;

		if (!last_col) begin
			col = XW'(x + 1);
			return 1'b0;
		end
		col = '0;
		if (!last_row) begin
			row = YW'(y + 1);
			return 1'b0;
		end

		if (fg_count == 0) begin
			r.frame_empty = 1'b1;
		end else begin
			r.min_x = lo_x[COORD_W-1:0];
			r.max_x = hi_x[COORD_W-1:0];
			r.min_y = lo_y[COORD_W-1:0];
			r.max_y = hi_y[COORD_W-1:0];
			r.col_sum = sum_x[SUM_W-1:0];
			r.row_sum = sum_y[SUM_W-1:0];
			r.area = fg_count;
			r.perimeter = perim_count;
		end
		row = '0;
		lo_x = '0;
		hi_x = '0;
		lo_y = '0;
		hi_y = '0;
		sum_x = '0;
		sum_y = '0;
		fg_count = '0;
		perim_count = '0;
		up_d1 = 1'b0;
		up_d2 = 1'b0;
		up2_d1 = 1'b0;
		cur_d1 = 1'b0;
		return 1'b1;
	endfunction

	task automatic send_pixel(input logic [7:0] value);
		int gap;
		shape_stats_t r;
		gap = draw_wait(pix_calm);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.mask_byte <= value;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
		if (step_pixel(value, r))
			expected_stats.push_back(r);
	endtask

	task automatic wait_idle();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.index <= REG_IMAGE_WIDTH;
		cfg.data <= w;
		do @(posedge clk); while (!cfg.ready);
		width_reg = w;
		cfg.index <= REG_IMAGE_HEIGHT;
		cfg.data <= h;
		do @(posedge clk); while (!cfg.ready);
		height_reg = h;
		cfg.valid <= 1'b0;
	endtask

	task automatic send_shape_frame(input shape_kind_t kind, input int density);
		int unsigned fw;
		int unsigned fh;
		int unsigned x0;
		int unsigned x1;
		int unsigned y0;
		int unsigned y1;
		int unsigned hx;
		int unsigned hy;
		bit with_hole;
		bit fg;
		fw = clamp_size(width_reg, MAX_WIDTH);
		fh = clamp_size(height_reg, MAX_HEIGHT);
		x0 = $urandom_range(0, fw - 1);
		x1 = $urandom_range(x0, fw - 1);
		y0 = $urandom_range(0, fh - 1);
		y1 = $urandom_range(y0, fh - 1);
		with_hole = 1'b0;
		hx = 0;
		hy = 0;
		if (x1 - x0 >= 2 && y1 - y0 >= 2 && $urandom_range(0, 1) == 1) begin
			with_hole = 1'b1;
			hx = $urandom_range(x0 + 1, x1 - 1);
			hy = $urandom_range(y0 + 1, y1 - 1);
		end
		for (int unsigned y = 0; y < fh; y++) begin
			for (int unsigned x = 0; x < fw; x++) begin
				case (kind)
					SHAPE_EMPTY: fg = 1'b0;
					SHAPE_FULL: fg = 1'b1;
					SHAPE_NOISE: fg = $urandom_range(0, 99) < density;
					default: begin
						fg = x >= x0 && x <= x1 && y >= y0 && y <= y1
							&& !(with_hole && x == hx && y == hy);
						if ($urandom_range(0, 29) == 0)
							fg = !fg;
					end
				endcase
				send_pixel(fg ? 8'($urandom_range(1, 255)) : 8'h00);
			end
		end
	endtask

	task automatic test_directed_frames();
		logic [7:0] full_corner [4] = '{8'hFF, 8'h80, 8'h01, 8'h5A};
		// Sizes below the floor act as a 2x2 frame; this one stays empty.
		set_frame_size(11'd0, 11'd1);
		repeat (4) send_pixel(8'h00);
		set_frame_size(11'd2, 11'd2);
		foreach (full_corner[i])
			send_pixel(full_corner[i]);
		// A solid 4x4 block with one hole, so inner pixels beside the hole become perimeter.
		set_frame_size(11'd4, 11'd4);
		for (int i = 0; i < 16; i++)
			send_pixel(i == 10 ? 8'h00 : 8'h01 << (i % 8));
	endtask

	task automatic test_size_extremes();
		set_frame_size(11'd64, 11'd1);
		send_shape_frame(SHAPE_NOISE, 50);
		set_frame_size(11'd1, 11'd64);
		send_shape_frame(SHAPE_NOISE, 90);
		set_frame_size(11'd3, 11'd2);
		send_shape_frame(SHAPE_BLOCK, 0);
		set_frame_size(11'd0, 11'd0);
		send_shape_frame(SHAPE_FULL, 0);
	endtask

	task automatic test_random_frames();
		int pick;
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		while (pixels_sent < 1450) begin
			if ($urandom_range(0, 9) < 7) begin
				w = CFG_DATA_W'($urandom_range(0, 9));
				h = CFG_DATA_W'($urandom_range(0, 9));
				if ($urandom_range(0, 7) == 0)
					w = CFG_DATA_W'($urandom_range(10, 24));
				set_frame_size(w, h);
			end
			pick = $urandom_range(0, 9);
			if (pick == 0)
				send_shape_frame(SHAPE_EMPTY, 0);
			else if (pick == 1)
				send_shape_frame(SHAPE_FULL, 0);
			else if (pick < 5)
				send_shape_frame(SHAPE_NOISE, $urandom_range(0, 100));
			else
				send_shape_frame(SHAPE_BLOCK, 0);
		end
	endtask

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		shape_stats_t want;
		if (res.valid && res.ready) begin
			if (expected_stats.size() == 0) begin
				errors++;
				$display("%0t: result expected none, actual frame_empty=%0d area=%0d",
					$time, res.frame_empty, res.area_count);
			end else begin
				want = expected_stats.pop_front();
				frames_checked++;
				check_field("frame_empty", 32'(want.frame_empty), 32'(res.frame_empty));
				check_field("box_min_x", 32'(want.min_x), 32'(res.box_min_x));
				check_field("box_max_x", 32'(want.max_x), 32'(res.box_max_x));
				check_field("box_min_y", 32'(want.min_y), 32'(res.box_min_y));
				check_field("box_max_y", 32'(want.max_y), 32'(res.box_max_y));
				check_field("column_sum", 32'(want.col_sum), 32'(res.column_sum));
				check_field("row_sum", 32'(want.row_sum), 32'(res.row_sum));
				check_field("area_count", 32'(want.area), 32'(res.area_count));
				check_field("edge_count", 32'(want.perimeter), 32'(res.edge_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("silhouette_shape_statistics: mismatch");
			$finish;
		end
	end

	initial begin : result_ready
		int gap;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_wait(res_calm);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
		end
	end

	initial begin
		arst_n <= 1'b0;
		pix.valid <= 1'b0;
		pix.mask_byte <= 8'h00;
		cfg.valid <= 1'b0;
		cfg.index <= REG_IMAGE_WIDTH;
		cfg.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_size_extremes();
		test_random_frames();
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Checked %0d frame results built from %0d pixels.", frames_checked,
			pixels_sent);
		$display("Frames ranged from sizes set below the 2x2 floor to 64-pixel rows and columns.");
		if (errors == 0) begin
			$display("silhouette_shape_statistics: match");
		end else begin
			$display("silhouette_shape_statistics: mismatch");
		end
		$finish;
	end

endmodule
